### rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat send window blocks.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int CNT_MAX_W = 7;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] KIND_SEND    = 3'd0;
  localparam logic [2:0] KIND_RETX    = 3'd1;
  localparam logic [2:0] KIND_REFUSED = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_IDLE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 2'd3;

  localparam logic [4:0]  RST_WINDOW  = 5'd1;
  localparam logic [15:0] RST_TIMEOUT = 16'd500;
  localparam logic [23:0] RST_TOTAL   = 24'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] ack_number;
  } srsw_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] seq_number;
    logic [23:0] segment_index;
    logic        last;
  } srsw_out_t;

  typedef enum logic [1:0] {
    OP_OFFER,
    OP_ACK,
    OP_TICK,
    OP_NONE
  } srsw_op_t;

  typedef struct packed {
    srsw_op_t    op;
    logic [14:0] ack_number;
  } srsw_qent_t;

  typedef struct packed {
    logic [4:0]  window_segments;
    logic [15:0] timeout_ticks;
    logic [23:0] total_segments;
    logic [14:0] start_seq;
    logic        seq_load;
  } srsw_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFER,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_POP,
    ST_ACK_END,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END,
    ST_NONE
  } srsw_state_t;

endpackage

### rtl/srsw_front.sv
// ----------------------------------------------------------------------------
// srsw_front
// Accepts command beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module srsw_front import srsw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  srsw_in_t   in_item,
  output logic       q_valid,
  input  logic       q_pop,
  output srsw_qent_t q_entry
);

  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  srsw_qent_t             buf_r [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  srsw_qent_t             cls;
  logic                   push;
  logic                   pop;

  always_comb begin
    cls.ack_number = in_item.ack_number;
    case (in_item.cmd)
      CMD_OFFER: cls.op = OP_OFFER;
      CMD_ACK:   cls.op = OP_ACK;
      CMD_TICK:  cls.op = OP_TICK;
      default:   cls.op = OP_NONE;
    endcase
  end

  assign in_ready = (fill_r != FILL_W'(QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_entry  = buf_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/srsw_back.sv
// ----------------------------------------------------------------------------
// srsw_back
// Window engine: sends, scans the window for acks and ticks, retires acked
// entries from the head and drives the result register.
// ----------------------------------------------------------------------------
module srsw_back import srsw_pkg::*; #(
  parameter int WINDOW_MAX   = 16,
  parameter int SEGMENT_STEP = 1024,
  parameter int SEQ_SPACE    = 30720
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srsw_cfg_t            cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  srsw_qent_t           q_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srsw_out_t            out_item,
  output logic [CNT_MAX_W-1:0] win_count
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int NSEQ_W = ($clog2(SEQ_SPACE) > 15) ? $clog2(SEQ_SPACE) : 15;
  localparam int SUM_W  = NSEQ_W + 1;
  localparam logic [CNT_W:0]   WIN_L    = (CNT_W + 1)'(WINDOW_MAX);
  localparam logic [SUM_W-1:0] SPACE_S  = SUM_W'(SEQ_SPACE);
  localparam logic [SUM_W-1:0] STEP_MOD = SUM_W'(SEGMENT_STEP % SEQ_SPACE);

  logic [NSEQ_W-1:0] seq_mem [WINDOW_MAX];
  logic [23:0]       idx_mem [WINDOW_MAX];
  logic [15:0]       tmr_mem [WINDOW_MAX];
  logic [NSEQ_W-1:0] rd_seq_q;
  logic [23:0]       rd_idx_q;
  logic [15:0]       rd_tmr_q;

  srsw_state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic [23:0]             sent_r, sent_nxt;
  logic [NSEQ_W-1:0]       next_seq_r, next_seq_nxt;
  logic [WINDOW_MAX-1:0]   acked_r, acked_nxt;
  logic [14:0]             ack_r, ack_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  srsw_out_t               pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  srsw_out_t               out_r, out_nxt;

  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] send_slot;
  logic              out_free;
  logic              room;
  logic              finished;
  logic              last_scan;
  logic [SUM_W-1:0]  seq_sum;
  logic [SUM_W-1:0]  seq_new;
  logic              ent_we;
  logic              tmr_we;
  logic [15:0]       tmr_wd;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= WIN_L) begin
      s = s - WIN_L;
    end
    return s[SLOT_W-1:0];
  endfunction

  function automatic srsw_out_t make_item(input logic [2:0]  kind,
                                          input logic [14:0] seq,
                                          input logic [23:0] idx,
                                          input logic        last);
    srsw_out_t r;
    r.kind          = kind;
    r.seq_number    = seq;
    r.segment_index = idx;
    r.last          = last;
    return r;
  endfunction

  assign rd_slot   = slot_of(head_r, scan_r);
  assign send_slot = slot_of(head_r, count_r);
  assign out_free  = !out_valid_r || out_ready;
  assign room      = (8'(count_r) < 8'(cfg.window_segments)) &&
                     (count_r != CNT_W'(WINDOW_MAX));
  assign finished  = (count_r == '0) && (sent_r >= cfg.total_segments);
  assign last_scan = ((scan_r + CNT_W'(1)) == count_r);
  assign seq_sum   = SUM_W'(next_seq_r) + STEP_MOD;
  assign seq_new   = (seq_sum >= SPACE_S) ? seq_sum - SPACE_S : seq_sum;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign win_count = CNT_MAX_W'(count_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    sent_nxt       = sent_r;
    next_seq_nxt   = next_seq_r;
    acked_nxt      = acked_r;
    ack_nxt        = ack_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    ent_we         = 1'b0;
    tmr_we         = 1'b0;
    tmr_wd         = cfg.timeout_ticks;

    case (state_r)
      ST_IDLE: begin
        if (SUM_W'(next_seq_r) >= SPACE_S) begin
          next_seq_nxt = NSEQ_W'(SUM_W'(next_seq_r) - SPACE_S);
        end else if (q_valid) begin
          q_pop    = 1'b1;
          ack_nxt  = q_entry.ack_number;
          scan_nxt = '0;
          case (q_entry.op)
            OP_OFFER: state_nxt = ST_OFFER;
            OP_ACK:   state_nxt = (count_r == '0) ? ST_POP : ST_ACK_RD;
            OP_TICK:  state_nxt = (count_r == '0) ? ST_TICK_END : ST_TICK_RD;
            default:  state_nxt = ST_NONE;
          endcase
        end
      end

      ST_OFFER: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if ((sent_r < cfg.total_segments) && room) begin
            ent_we                 = 1'b1;
            acked_nxt[send_slot]   = 1'b0;
            count_nxt              = count_r + CNT_W'(1);
            sent_nxt               = sent_r + 24'd1;
            next_seq_nxt           = NSEQ_W'(seq_new);
            out_nxt = make_item(KIND_SEND, seq_new[14:0], sent_r, 1'b1);
          end else if (finished) begin
            out_nxt = make_item(KIND_DONE, '0, '0, 1'b1);
          end else begin
            out_nxt = make_item(KIND_REFUSED, '0, '0, 1'b1);
          end
        end
      end

      ST_ACK_RD: begin
        state_nxt = ST_ACK_EV;
      end

      ST_ACK_EV: begin
        if (rd_seq_q == NSEQ_W'(ack_r)) begin
          acked_nxt[rd_slot] = 1'b1;
        end
        scan_nxt  = scan_r + CNT_W'(1);
        state_nxt = last_scan ? ST_POP : ST_ACK_RD;
      end

      ST_POP: begin
        if ((count_r != '0) && acked_r[head_r]) begin
          acked_nxt[head_r] = 1'b0;
          head_nxt          = slot_of(head_r, CNT_W'(1));
          count_nxt         = count_r - CNT_W'(1);
        end else begin
          state_nxt = ST_ACK_END;
        end
      end

      ST_ACK_END: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt = make_item(finished ? KIND_DONE : KIND_ACK, '0, '0, 1'b1);
        end
      end

      ST_TICK_RD: begin
        state_nxt = ST_TICK_EV;
      end

      ST_TICK_EV: begin
        if (acked_r[rd_slot]) begin
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = last_scan ? ST_TICK_END : ST_TICK_RD;
        end else if (rd_tmr_q <= 16'd1) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt  = make_item(KIND_RETX, rd_seq_q[14:0], rd_idx_q, 1'b0);
            tmr_we    = 1'b1;
            tmr_wd    = cfg.timeout_ticks;
            scan_nxt  = scan_r + CNT_W'(1);
            state_nxt = last_scan ? ST_TICK_END : ST_TICK_RD;
          end
        end else begin
          tmr_we    = 1'b1;
          tmr_wd    = rd_tmr_q - 16'd1;
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = last_scan ? ST_TICK_END : ST_TICK_RD;
        end
      end

      ST_TICK_END: begin
        if (out_free) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = make_item(KIND_IDLE, '0, '0, 1'b1);
          end
        end
      end

      ST_NONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = make_item(KIND_IDLE, '0, '0, 1'b1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg.seq_load && (sent_r == '0)) begin
      next_seq_nxt = NSEQ_W'(cfg.start_seq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      scan_r       <= '0;
      sent_r       <= '0;
      next_seq_r   <= '0;
      acked_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      scan_r       <= scan_nxt;
      sent_r       <= sent_nxt;
      next_seq_r   <= next_seq_nxt;
      acked_r      <= acked_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ack_r  <= ack_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      seq_mem[send_slot] <= NSEQ_W'(seq_new);
      idx_mem[send_slot] <= sent_r;
    end
    if (ent_we) begin
      tmr_mem[send_slot] <= cfg.timeout_ticks;
    end else if (tmr_we) begin
      tmr_mem[rd_slot] <= tmr_wd;
    end
    rd_seq_q <= seq_mem[rd_slot];
    rd_idx_q <= idx_mem[rd_slot];
    rd_tmr_q <= tmr_mem[rd_slot];
  end

endmodule

### rtl/selective_repeat_send_window_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_send_window_top
// Sender window of a selective-repeat transfer with retransmit timers.
// ----------------------------------------------------------------------------
// Command beats enter on in_valid/in_ready (offer, ack, tick); each gives one
// or more result beats on out_valid/out_ready, the final one flagged by last.
// Registers are written through cfg_we/cfg_index/cfg_wdata with no wait.
// A two-entry queue sits in front of the window engine, so commands are taken
// while the engine works and while a result waits in the output register.
// An ack or tick makes the engine scan every outstanding window entry, one at
// a time through the registered read of the entry memory; an ack then retires
// acked entries from the head.
// A stalled receiver holds the engine once a further result is due; the
// queue fills and in_ready drops.
// Reset empties the window and the queue and restores the register defaults;
// there is no clearing pass, so the block takes commands at once.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_top import srsw_pkg::*; #(
  parameter int WINDOW_MAX   = 16,
  parameter int SEGMENT_STEP = 1024,
  parameter int SEQ_SPACE    = 30720
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srsw_in_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srsw_out_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [4:0]           window_r;
  logic [15:0]          timeout_r;
  logic [23:0]          total_r;
  srsw_cfg_t            cfg;
  logic                 q_valid;
  logic                 q_pop;
  srsw_qent_t           q_entry;
  logic [CNT_MAX_W-1:0] win_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= RST_WINDOW;
      timeout_r <= RST_TIMEOUT;
      total_r   <= RST_TOTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:  window_r  <= cfg_wdata[4:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
        REG_TOTAL:   total_r   <= cfg_wdata[23:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    cfg.window_segments = window_r;
    cfg.timeout_ticks   = timeout_r;
    cfg.total_segments  = total_r;
    cfg.start_seq       = cfg_wdata[14:0];
    cfg.seq_load        = cfg_we && (cfg_index == REG_START_SEQ);
  end

  srsw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_entry  (q_entry)
  );

  srsw_back #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SEGMENT_STEP (SEGMENT_STEP),
    .SEQ_SPACE    (SEQ_SPACE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .win_count (win_count)
  );

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    win_count <= CNT_MAX_W'(WINDOW_MAX))
    else $error("window count above maximum");

  a_done_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind == KIND_DONE)) |-> (win_count == '0))
    else $error("done reported with segments outstanding");

  a_plain_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind != KIND_SEND) && (out_item.kind != KIND_RETX))
      |-> ((out_item.seq_number == '0) && (out_item.segment_index == '0)))
    else $error("status result carries segment fields");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat send window.
// A tracker mirrors the window (slots, timers, head, sequence numbering) and
// queues the result beats due for every accepted command; each result beat is
// checked field by field against the oldest one. A directed opening covers
// the corner cases, then random offer/ack/tick traffic runs under several
// register settings and idle/stall mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb import srsw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX   = 16;
  localparam int SEG_STEP  = 1024;
  localparam int SEQ_SPACE = 30720;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEG_ITEMS = 50;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  class send_window_tracker;
    int unsigned win_setting;
    int unsigned timeout;
    int unsigned start_value;
    int unsigned total;
    logic [14:0] slot_seq [WIN_MAX];
    logic [23:0] slot_index [WIN_MAX];
    bit          slot_acked [WIN_MAX];
    int unsigned slot_timer [WIN_MAX];
    int unsigned head;
    int unsigned outstanding;
    int unsigned sent;
    int unsigned next_seq;
    srsw_out_t   pending [$];
    srsw_out_t   staged;
    bit          have_staged;
    int unsigned errors;
    int unsigned commands;
    int unsigned kind_seen [6];

    function new();
      win_setting = RST_WINDOW;
      timeout = RST_TIMEOUT;
      start_value = 0;
      total = RST_TOTAL;
      head = 0;
      outstanding = 0;
      sent = 0;
      next_seq = 0;
      errors = 0;
      commands = 0;
      foreach (slot_acked[i]) slot_acked[i] = 1'b0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_WINDOW:  win_setting = data[4:0];
        REG_TIMEOUT: timeout = data[15:0];
        REG_START_SEQ: begin
          start_value = data[14:0];
          if (sent == 0) next_seq = start_value;
        end
        REG_TOTAL:   total = data[23:0];
        default: ;
      endcase
    endfunction

    function bit transfer_done();
      return outstanding == 0 && sent >= total;
    endfunction

    function logic [14:0] outstanding_seq(int unsigned k);
      return slot_seq[(head + k) % WIN_MAX];
    endfunction

    function void stage(logic [2:0] kind, logic [14:0] seq, logic [23:0] idx);
      if (have_staged) pending = {pending, staged};
      staged.kind = kind;
      staged.seq_number = seq;
      staged.segment_index = idx;
      staged.last = 1'b0;
      have_staged = 1'b1;
    endfunction

    function void take_command(srsw_in_t c);
      int unsigned room;
      int unsigned s;
      have_staged = 1'b0;
      commands++;
      case (c.cmd)
        CMD_OFFER: begin
          room = (win_setting > WIN_MAX) ? WIN_MAX : win_setting;
          if (sent < total && outstanding < room) begin
            s = (head + outstanding) % WIN_MAX;
            next_seq = (next_seq + SEG_STEP) % SEQ_SPACE;
            slot_seq[s] = next_seq[14:0];
            slot_index[s] = sent[23:0];
            slot_acked[s] = 1'b0;
            slot_timer[s] = timeout;
            outstanding++;
            stage(KIND_SEND, next_seq[14:0], sent[23:0]);
            sent++;
          end else if (transfer_done()) begin
            stage(KIND_DONE, '0, '0);
          end else begin
            stage(KIND_REFUSED, '0, '0);
          end
        end
        CMD_ACK: begin
          for (int unsigned k = 0; k < outstanding; k++) begin
            s = (head + k) % WIN_MAX;
            if (slot_seq[s] == c.ack_number) slot_acked[s] = 1'b1;
          end
          while (outstanding > 0 && slot_acked[head]) begin
            slot_acked[head] = 1'b0;
            head = (head + 1) % WIN_MAX;
            outstanding--;
          end
          stage(transfer_done() ? KIND_DONE : KIND_ACK, '0, '0);
        end
        CMD_TICK: begin
          for (int unsigned k = 0; k < outstanding; k++) begin
            s = (head + k) % WIN_MAX;
            if (!slot_acked[s]) begin
              if (slot_timer[s] <= 1) begin
                slot_timer[s] = timeout;
                stage(KIND_RETX, slot_seq[s], slot_index[s]);
              end else begin
                slot_timer[s]--;
              end
            end
          end
          if (!have_staged) stage(KIND_IDLE, '0, '0);
        end
        default: stage(KIND_IDLE, '0, '0);
      endcase
      staged.last = 1'b1;
      pending = {pending, staged};
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(srsw_out_t got);
      srsw_out_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing due: kind %0d seq %0d index %0d",
               got.kind, got.seq_number, got.segment_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind < 6) kind_seen[got.kind]++;
      compare_field("kind", 24'(want.kind), 24'(got.kind));
      compare_field("seq_number", 24'(want.seq_number), 24'(got.seq_number));
      compare_field("segment_index", want.segment_index, got.segment_index);
      compare_field("last", 24'(want.last), 24'(got.last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  srsw_in_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  srsw_out_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  send_window_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned blocked_cycles;
  int unsigned cycle_count;

  selective_repeat_send_window_top #(
    .WINDOW_MAX  (WIN_MAX),
    .SEGMENT_STEP(SEG_STEP),
    .SEQ_SPACE   (SEQ_SPACE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // check outputs before noting new commands so a premature beat is caught
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.match_result(out_item);
      if (in_valid && in_ready) tracker.take_command(in_item);
      if (in_valid && !in_ready) blocked_cycles++;
      if (cfg_we) tracker.write_reg(cfg_index, cfg_wdata);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic srsw_in_t command(logic [1:0] cmd, logic [14:0] ack);
    srsw_in_t c;
    c.cmd = cmd;
    c.ack_number = ack;
    return c;
  endfunction

  function automatic srsw_in_t pick_command();
    srsw_in_t    c;
    int unsigned r;
    r = $urandom_range(99);
    c.ack_number = 15'($urandom_range(15'h7FFF));
    if (r < 45) begin
      c.cmd = CMD_OFFER;
    end else if (r < 72) begin
      c.cmd = CMD_ACK;
      if (tracker.outstanding > 0 && $urandom_range(9) < 8)
        c.ack_number = tracker.outstanding_seq($urandom_range(tracker.outstanding - 1));
    end else if (r < 96) begin
      c.cmd = CMD_TICK;
    end else begin
      c.cmd = CMD_UNKNOWN;
    end
    return c;
  endfunction

  task automatic push_command(srsw_in_t c);
    in_valid <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_pause();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic program_window(logic [4:0] win, logic [15:0] tmo, logic [14:0] start,
                                logic [23:0] total);
    cfg_write(REG_WINDOW, 24'(win));
    cfg_write(REG_TIMEOUT, 24'(tmo));
    cfg_write(REG_START_SEQ, 24'(start));
    cfg_write(REG_TOTAL, total);
    cfg_we <= 1'b0;
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    blocked_cycles = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero window, start beyond the sequence space
    program_window(5'd0, 16'd0, 15'h7FFF, 24'd3);
    push_command(command(CMD_OFFER, 15'h7FFF));
    push_command(command(CMD_ACK, 15'd0));
    push_command(command(CMD_TICK, 15'h7FFF));
    push_command(command(CMD_UNKNOWN, 15'h7FFF));
    wait_drained();

    // oversized window, zero timeout, out-of-order acks
    program_window(5'd31, 16'd0, 15'h7FFF, 24'd3);
    repeat (4) push_command(command(CMD_OFFER, 15'd0));
    push_command(command(CMD_TICK, 15'd0));
    push_command(command(CMD_ACK, tracker.outstanding_seq(1)));
    push_command(command(CMD_TICK, 15'd0));
    push_command(command(CMD_ACK, tracker.outstanding_seq(0)));
    push_command(command(CMD_ACK, tracker.outstanding_seq(0)));
    push_command(command(CMD_OFFER, 15'd0));
    wait_drained();

    // single-slot window with a short timer
    program_window(5'd1, 16'd2, 15'd0, 24'(tracker.sent + 2));
    repeat (2) push_command(command(CMD_OFFER, 15'd0));
    repeat (2) push_command(command(CMD_TICK, 15'd0));
    push_command(command(CMD_ACK, tracker.outstanding_seq(0)));
    push_command(command(CMD_OFFER, 15'd0));
    push_command(command(CMD_ACK, tracker.outstanding_seq(0)));
    push_command(command(CMD_TICK, 15'd0));
    wait_drained();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (seg)
        0: program_window(5'd16, 16'd3, 15'($urandom_range(15'h7FFF)),
                          24'(tracker.sent + 40));
        1: program_window(5'd31, 16'd1, 15'd0, 24'hFFFFFF);
        2: program_window(5'd4, 16'd2, 15'd30719, 24'(tracker.sent + 12));
        3: program_window(5'd1, 16'hFFFF, 15'h7FFF, 24'(tracker.sent + 20));
        4: program_window(5'd8, 16'd0, 15'($urandom_range(15'h7FFF)),
                          24'(tracker.sent + 30));
        5: program_window(5'd16, 16'd1, 15'd0, 24'(tracker.sent + 25));
        6: program_window(5'($urandom_range(2, 15)), 16'($urandom_range(1, 5)),
                          15'($urandom_range(15'h7FFF)),
                          24'(tracker.sent + $urandom_range(5, 30)));
        default: program_window(5'd12, 16'd4, 15'd30719, 24'hFFFFFF);
      endcase
      // hold the receiver off so the engine stalls, the queue fills and the input stalls
      if (seg == 0) hold_cycles = 400;
      repeat (SEG_ITEMS) begin
        sender_pause();
        push_command(pick_command());
      end
      wait_drained();
    end

    repeat (40) @(negedge clk);
    $display("covered %0d commands over 11 window settings and four idle/stall mixes,",
             tracker.commands);
    $display("%0d send, %0d retransmit, %0d refused, %0d ack, %0d done, %0d idle beats; %0d %s",
             tracker.kind_seen[KIND_SEND], tracker.kind_seen[KIND_RETX],
             tracker.kind_seen[KIND_REFUSED], tracker.kind_seen[KIND_ACK],
             tracker.kind_seen[KIND_DONE], tracker.kind_seen[KIND_IDLE],
             blocked_cycles, "cycles with the input held back");
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
